@@ hdl/fla_pkg.sv @@
// Shared definitions for the free list allocator: pool size default,
// command codes and the controller state type. No dependencies.
package fla_pkg;

	localparam int POOL_ENTRIES_DEF = 1024;
	localparam int INDEX_W = 10;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} fla_state_t;

endpackage

@@ hdl/free_list_allocator_core.sv @@
// Free list allocator core: controller, head register and output staging.
// Depends on fla_pkg and the fla_ram link store.
//
// Usage: one command per input transfer (cmd, free_index); exactly one
// result per command (granted, alloc_index), in command order. Both channels
// use valid/stall: a transfer happens on a rising edge with valid high and
// stall low.
// A free, a free of an out-of-range index, and an allocate from an empty pool
// are settled in the cycle they are accepted; the result is registered into
// the output staging and the next command can follow at once. An allocate from a
// non-empty pool also passes through the lookup state, since the head entry's link
// must come back from the registered read port of the link RAM before the next pop;
// its result is registered at the end of the lookup state.
// After reset the block walks the link RAM, one entry per cycle, writing
// entry i with i+1; in_stall stays high until the walk is done.
// A result waiting under out_stall sits in the output register; one more
// command is still accepted and its result parks in a spare register.
// Besides the clear walk and the lookup state, input stalls only when both are occupied.
module free_list_allocator_core #(
	parameter int POOL_ENTRIES = fla_pkg::POOL_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cmd,
	input  logic [fla_pkg::INDEX_W-1:0] free_index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       granted,
	output logic [fla_pkg::INDEX_W-1:0] alloc_index
);

	localparam int IW = $clog2(POOL_ENTRIES);
	localparam int LW = $clog2(POOL_ENTRIES + 1);
	localparam int WW = (LW > fla_pkg::INDEX_W) ? LW : fla_pkg::INDEX_W;

	fla_pkg::fla_state_t state_q, state_d;

	logic [IW-1:0] clr_q;
	logic [LW-1:0] head_q;
	logic          pend_valid_q;
	logic          pend_granted_q;
	logic [fla_pkg::INDEX_W-1:0] pend_index_q;
	logic          out_valid_q;
	logic          out_granted_q;
	logic [fla_pkg::INDEX_W-1:0] out_index_q;

	logic          accept;
	logic          head_empty;
	logic          free_ok;
	logic [WW-1:0] idx_w;
	logic [WW-1:0] head_w;
	logic          imm_res;
	logic          lk_res;
	logic          res_valid;
	logic          res_granted;
	logic [fla_pkg::INDEX_W-1:0] res_index;
	logic          out_free;
	logic          clear_done;
	logic          free_wr;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [LW-1:0] ram_wdata;
	logic [LW-1:0] ram_rdata;
	logic [LW-1:0] next_head;

	assign in_stall   = (state_q != fla_pkg::ST_IDLE) || pend_valid_q;
	assign accept     = in_valid && !in_stall;
	assign head_empty = head_q >= LW'(POOL_ENTRIES);
	assign idx_w      = WW'(free_index);
	assign head_w     = WW'(head_q);
	assign free_ok    = idx_w < WW'(POOL_ENTRIES);
	assign free_wr    = accept && (cmd == fla_pkg::CMD_FREE) && free_ok;
	assign clear_done = clr_q == IW'(POOL_ENTRIES - 1);

	// Frees and empty allocates finish on acceptance; a real pop finishes
	// in the lookup cycle, where head_q still holds the popped index.
	assign imm_res   = accept && ((cmd == fla_pkg::CMD_FREE) || head_empty);
	assign lk_res    = state_q == fla_pkg::ST_LOOKUP;
	assign res_valid = imm_res || lk_res;

	always_comb begin
		if (lk_res) begin
			res_granted = 1'b1;
			res_index   = head_w[fla_pkg::INDEX_W-1:0];
		end else begin
			res_granted = (cmd == fla_pkg::CMD_FREE) && free_ok;
			res_index   = '0;
		end
	end

	// Links never exceed the end mark, but clamp anyway so a bad word reads as empty.
	assign next_head = (ram_rdata > LW'(POOL_ENTRIES)) ? LW'(POOL_ENTRIES) : ram_rdata;

	assign ram_we    = (state_q == fla_pkg::ST_CLEAR) || free_wr;
	assign ram_waddr = (state_q == fla_pkg::ST_CLEAR) ? clr_q : idx_w[IW-1:0];
	assign ram_wdata = (state_q == fla_pkg::ST_CLEAR) ? (LW'(clr_q) + LW'(1)) : head_q;

	fla_ram #(
		.WIDTH(LW),
		.DEPTH(POOL_ENTRIES)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(head_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fla_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fla_pkg::ST_CLEAR: begin
				if (clear_done) begin
					state_d = fla_pkg::ST_IDLE;
				end
			end
			fla_pkg::ST_IDLE: begin
				if (accept && (cmd == fla_pkg::CMD_ALLOC) && !head_empty) begin
					state_d = fla_pkg::ST_LOOKUP;
				end
			end
			fla_pkg::ST_LOOKUP: begin
				state_d = fla_pkg::ST_IDLE;
			end
			default: begin
				state_d = fla_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			head_q <= '0;
		end else begin
			if (state_q == fla_pkg::ST_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (free_wr) begin
				head_q <= LW'(idx_w);
			end else if (lk_res) begin
				head_q <= next_head;
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// The spare register only fills while the output register is stalled,
	// and input stalls while it is full, so at most two results are held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				if (pend_valid_q) begin
					out_valid_q  <= 1'b1;
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q <= res_valid;
				end
			end else if (res_valid) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_granted_q <= pend_granted_q;
				out_index_q   <= pend_index_q;
			end else if (res_valid) begin
				out_granted_q <= res_granted;
				out_index_q   <= res_index;
			end
		end else if (res_valid) begin
			pend_granted_q <= res_granted;
			pend_index_q   <= res_index;
		end
	end

	assign out_valid   = out_valid_q;
	assign granted     = out_granted_q;
	assign alloc_index = out_index_q;

endmodule

@@ hdl/fla_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the link store of the allocator; no package dependencies.
module fla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/fla_checker.sv @@
// Port-level checker for the free list allocator core, bound to free_list_allocator_core.
// Depends on fla_pkg for the command codes and index width.
module fla_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        cmd,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        granted,
	input logic [fla_pkg::INDEX_W-1:0] alloc_index
);

	// A held result keeps its payload until the transfer happens.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted) && $stable(alloc_index))
		else $error("result changed while stalled");

	// A refused command never carries an index.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> alloc_index == '0)
		else $error("failed command returned a nonzero index");

	// After a command transfer the block either shows a result or is busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid || in_stall)
		else $error("accepted command neither produced a result nor stalled input");

	// A free returns no index; only an allocate can return one.
	a_free_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == fla_pkg::CMD_FREE) && !out_valid
		|=> !out_valid || alloc_index == '0)
		else $error("free returned a nonzero index");

endmodule

bind free_list_allocator_core fla_checker u_fla_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.cmd        (cmd),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.granted    (granted),
	.alloc_index(alloc_index)
);
